[sv/pngsd_pkg.sv]
package pngsd_pkg;

  localparam int DEF_MAX_SIDE  = 1024;
  localparam int DEF_BLOCK_MAX = 65535;
  localparam int CFG_W         = 11;
  localparam int PIX_W         = 32;
  localparam int MAX_RESULTS   = 53;
  localparam int START_LAST    = 42;
  localparam int TAIL_LAST     = 19;
  localparam int ADLER_MOD     = 65521;
  localparam int Q_DEPTH       = 2;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [31:0] IEND_CRC  = 32'hAE426082;
  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             start;
    logic             col0;
    logic             tail_only;
    logic             tail_inline;
  } item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'd137;
      3'd1: r = 8'd80;
      3'd2: r = 8'd78;
      3'd3: r = 8'd71;
      3'd4: r = 8'd13;
      3'd5: r = 8'd10;
      3'd6: r = 8'd26;
      3'd7: r = 8'd10;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] r;
    unique case (k)
      2'd0: r = v[31:24];
      2'd1: r = v[23:16];
      2'd2: r = v[15:8];
      2'd3: r = v[7:0];
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/png_stored_deflate_encoder.sv]
// PNG writer for square RGBA8 images, stored (uncompressed) deflate blocks.
// Config: cfg_we/cfg_wdata write the image side (0 reads as 1, clamped to
//   MAX_SIDE); a write restarts the image. Write only while idle.
// Input: in_valid/in_ready/in_pixel, one RGBA pixel per word, raster order.
// Output: out_valid/out_ready/out_byte, one file byte per word; out_run_last
//   marks the last byte caused by a pixel, out_file_end the last byte of the file.
// The first pixel also yields signature, IHDR, IDAT length/type and zlib
//   header; the last yields Adler-32, IDAT CRC and IEND (for a 1x1 image the
//   trailer comes with the next word, whose pixel is ignored).
// A taken word goes through the word queue and the load state to out_byte.
// Throughput: one byte per cycle while out_ready is high, plus a load state per
//   pixel; a pixel yields 4 bytes, 5 with a filter byte, +5 per block header,
//   43 more on the first pixel, 20 more on the last. Set by the byte sequencer.
// A 2-deep word queue lets input be taken while the output stalls; with
//   out_ready low the output word holds and the sequencer waits.
// Reset: side 1, waiting for the first pixel of an image.
module png_stored_deflate_encoder #(
  parameter int MAX_SIDE  = pngsd_pkg::DEF_MAX_SIDE,
  parameter int BLOCK_MAX = pngsd_pkg::DEF_BLOCK_MAX
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pngsd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pngsd_pkg::PIX_W-1:0] in_pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_run_last,
  output logic                        out_file_end
);
  import pngsd_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int RAW_W  = $clog2(longint'(MAX_SIDE) * (4 * longint'(MAX_SIDE) + 1) + 1);

  logic              q_wr, q_rd, q_full, q_empty;
  item_t             wr_item, rd_item;
  logic [SIDE_W-1:0] side;
  logic [RAW_W-1:0]  raw_total;

  pngsd_front #(
    .MAX_SIDE (MAX_SIDE),
    .SIDE_W   (SIDE_W),
    .RAW_W    (RAW_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_item    (wr_item),
    .side      (side),
    .raw_total (raw_total)
  );

  pngsd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_item (wr_item),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_item (rd_item),
    .empty   (q_empty)
  );

  pngsd_back #(
    .MAX_SIDE  (MAX_SIDE),
    .BLOCK_MAX (BLOCK_MAX),
    .SIDE_W    (SIDE_W),
    .RAW_W     (RAW_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .side         (side),
    .raw_total    (raw_total),
    .q_empty      (q_empty),
    .q_item       (rd_item),
    .q_rd         (q_rd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_file_end (out_file_end)
  );

endmodule

[sv/pngsd_fifo.sv]
module pngsd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  pngsd_pkg::item_t  wr_item,
  output logic              full,
  input  logic              rd_en,
  output pngsd_pkg::item_t  rd_item,
  output logic              empty
);
  import pngsd_pkg::*;

  item_t      mem_r [Q_DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'(Q_DEPTH));
  assign empty   = (cnt_r == 2'd0);
  assign rd_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = ~wp_r;
    end
    if (rd_en) begin
      rp_nxt = ~rp_r;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(Q_DEPTH)) else $error("queue count out of range");

endmodule

[sv/pngsd_front.sv]
module pngsd_front #(
  parameter int MAX_SIDE = pngsd_pkg::DEF_MAX_SIDE,
  parameter int SIDE_W   = 11,
  parameter int RAW_W    = 23
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pngsd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pngsd_pkg::PIX_W-1:0] in_pixel,
  input  logic                        q_full,
  output logic                        q_wr,
  output pngsd_pkg::item_t            q_item,
  output logic [SIDE_W-1:0]           side,
  output logic [RAW_W-1:0]            raw_total
);
  import pngsd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_PIX  = 3'b010,
    PH_TAIL = 3'b100
  } phase_t;

  phase_t            ph_r, ph_nxt;
  logic [SIDE_W-1:0] side_r, side_nxt, col_r, col_nxt, row_r, row_nxt;
  logic [RAW_W-1:0]  raw_r, raw_nxt, se;
  logic [SIDE_W-1:0] c, r, cn, rn;
  logic              start, last;

  assign in_ready  = !q_full;
  assign q_wr      = in_valid && !q_full;
  assign side      = side_r;
  assign raw_total = raw_r;

  always_comb begin
    start = (ph_r == PH_WAIT);
    c     = start ? '0 : col_r;
    r     = start ? '0 : row_r;
    cn    = c + SIDE_W'(1);
    rn    = r;
    if (cn >= side_r) begin
      cn = '0;
      rn = r + SIDE_W'(1);
    end
    last = (rn >= side_r);

    q_item.pixel       = in_pixel;
    q_item.start       = start;
    q_item.col0        = (c == '0);
    q_item.tail_only   = (ph_r == PH_TAIL);
    q_item.tail_inline = last && !start && (ph_r != PH_TAIL);

    ph_nxt   = ph_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    side_nxt = side_r;
    raw_nxt  = raw_r;
    se       = '0;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        side_nxt = SIDE_W'(1);
      end else if (32'(cfg_wdata) > 32'(MAX_SIDE)) begin
        side_nxt = SIDE_W'(MAX_SIDE);
      end else begin
        side_nxt = SIDE_W'(cfg_wdata);
      end
      se      = RAW_W'(side_nxt);
      raw_nxt = se * ((se << 2) + RAW_W'(1));
      ph_nxt  = PH_WAIT;
    end else if (q_wr) begin
      if (ph_r == PH_TAIL) begin
        ph_nxt = PH_WAIT;
      end else begin
        col_nxt = cn;
        row_nxt = rn;
        if (last) begin
          ph_nxt = start ? PH_TAIL : PH_WAIT;
        end else begin
          ph_nxt = PH_PIX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_WAIT;
      col_r  <= '0;
      row_r  <= '0;
      side_r <= SIDE_W'(1);
      raw_r  <= RAW_W'(5);
    end else begin
      ph_r   <= ph_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      side_r <= side_nxt;
      raw_r  <= raw_nxt;
    end
  end

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> ph_r == PH_WAIT) else $error("config write did not restart image");

endmodule

[sv/pngsd_back.sv]
module pngsd_back #(
  parameter int MAX_SIDE  = pngsd_pkg::DEF_MAX_SIDE,
  parameter int BLOCK_MAX = pngsd_pkg::DEF_BLOCK_MAX,
  parameter int SIDE_W    = 11,
  parameter int RAW_W     = 23
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIDE_W-1:0] side,
  input  logic [RAW_W-1:0]  raw_total,
  input  logic              q_empty,
  input  pngsd_pkg::item_t  q_item,
  output logic              q_rd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_file_end
);
  import pngsd_pkg::*;

  localparam longint RAW_MAX = longint'(MAX_SIDE) * (4 * longint'(MAX_SIDE) + 1);
  localparam longint X_MAX   = RAW_MAX + longint'(BLOCK_MAX) - 1;
  localparam int     X_W     = $clog2(X_MAX + 1);
  localparam longint RECIP   = (longint'(1) << X_W) / longint'(BLOCK_MAX);
  localparam int     M_W     = $clog2(RECIP + 1);
  localparam int     B_W     = $clog2(BLOCK_MAX + 1);
  localparam int     P_W     = X_W + M_W;
  localparam int     QB_W    = X_W + B_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_RAW   = 4'b0100,
    ST_TAIL  = 4'b1000
  } state_t;

  // IDAT length: 6 + raw + 5 * ceil(raw / BLOCK_MAX), registered after a config write
  logic [X_W-1:0]  x_r, q0_r, nb_r;
  logic [P_W-1:0]  p_r;
  logic [QB_W-1:0] qb_r;
  logic [31:0]     len_r;

  always_ff @(posedge clk) begin
    x_r   <= X_W'(raw_total) + X_W'(BLOCK_MAX - 1);
    p_r   <= P_W'(x_r) * P_W'(RECIP);
    q0_r  <= X_W'(p_r >> X_W);
    qb_r  <= QB_W'(q0_r) * QB_W'(BLOCK_MAX);
    nb_r  <= ((QB_W'(x_r) - qb_r) >= QB_W'(BLOCK_MAX)) ? q0_r + X_W'(1) : q0_r;
    len_r <= 32'd6 + 32'(raw_total) + 32'(nb_r) + (32'(nb_r) << 2);
  end

  state_t           st_r, st_nxt;
  logic [5:0]       idx_r, idx_nxt, ec_r, ec_nxt;
  logic [2:0]       rk_r, rk_nxt, hi_r, hi_nxt;
  logic [RAW_W-1:0] rl_r, rl_nxt;
  logic [15:0]      bl_r, bl_nxt, al_r, al_nxt, ah_r, ah_nxt;
  logic [31:0]      hcrc_r, hcrc_nxt, icrc_r, icrc_nxt;
  logic [PIX_W-1:0] px_r, px_nxt;
  logic             ti_r, ti_nxt;
  logic             out_valid_r, out_valid_nxt, out_run_last_r, out_run_last_nxt;
  logic             out_file_end_r, out_file_end_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;

  logic        adv, last_c, fe_c, hupd, iupd;
  logic [7:0]  b, rawb;
  logic [15:0] blk;
  logic [31:0] side32, adl;
  logic [16:0] alsum, ahsum;

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_run_last_r;
  assign out_file_end = out_file_end_r;

  always_comb begin
    side32 = 32'(side);
    adl    = {ah_r, al_r};
    blk    = (32'(rl_r) > 32'(BLOCK_MAX)) ? 16'(BLOCK_MAX) : 16'(rl_r);
    unique case (rk_r)
      3'd0:    rawb = 8'd0;
      3'd1:    rawb = px_r[31:24];
      3'd2:    rawb = px_r[23:16];
      3'd3:    rawb = px_r[15:8];
      default: rawb = px_r[7:0];
    endcase
    alsum = 17'(al_r) + 17'(rawb);
    if (alsum >= 17'(ADLER_MOD)) begin
      alsum = alsum - 17'(ADLER_MOD);
    end
    ahsum = 17'(ah_r) + alsum;
    if (ahsum >= 17'(ADLER_MOD)) begin
      ahsum = ahsum - 17'(ADLER_MOD);
    end

    adv    = (st_r != ST_IDLE) && (!out_valid_r || out_ready);
    q_rd   = 1'b0;
    b      = 8'd0;
    last_c = 1'b0;
    fe_c   = 1'b0;
    hupd   = 1'b0;
    iupd   = 1'b0;

    st_nxt  = st_r;
    idx_nxt = idx_r;
    ec_nxt  = ec_r;
    rk_nxt  = rk_r;
    hi_nxt  = hi_r;
    rl_nxt  = rl_r;
    bl_nxt  = bl_r;
    al_nxt  = al_r;
    ah_nxt  = ah_r;
    px_nxt  = px_r;
    ti_nxt  = ti_r;

    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_rd    = 1'b1;
          idx_nxt = '0;
          ec_nxt  = '0;
          hi_nxt  = '0;
          px_nxt  = q_item.pixel;
          ti_nxt  = q_item.tail_inline;
          rk_nxt  = q_item.col0 ? 3'd0 : 3'd1;
          if (q_item.tail_only) begin
            st_nxt = ST_TAIL;
          end else if (q_item.start) begin
            st_nxt = ST_START;
            rl_nxt = raw_total;
            bl_nxt = '0;
            al_nxt = 16'd1;
            ah_nxt = '0;
          end else begin
            st_nxt = ST_RAW;
          end
        end
      end
      ST_START: begin
        priority if (idx_r < 6'd8) begin
          b = sig_byte(idx_r[2:0]);
        end else if (idx_r < 6'd12) begin
          b = (idx_r == 6'd11) ? 8'd13 : 8'd0;
        end else if (idx_r < 6'd16) begin
          b = be_byte(32'h49484452, idx_r[1:0]);
        end else if (idx_r < 6'd24) begin
          b = be_byte(side32, idx_r[1:0]);
        end else if (idx_r < 6'd29) begin
          b = (idx_r == 6'd24) ? 8'd8 : ((idx_r == 6'd25) ? 8'd6 : 8'd0);
        end else if (idx_r < 6'd33) begin
          b = be_byte(~hcrc_r, 2'(idx_r - 6'd29));
        end else if (idx_r < 6'd37) begin
          b = be_byte(len_r, 2'(idx_r - 6'd33));
        end else if (idx_r < 6'd41) begin
          b = be_byte(32'h49444154, 2'(idx_r - 6'd37));
        end else begin
          b = (idx_r == 6'd41) ? ZLIB_CMF : ZLIB_FLG;
        end
        if (adv) begin
          hupd = (idx_r >= 6'd12) && (idx_r < 6'd29);
          iupd = (idx_r >= 6'd37);
          if (idx_r == 6'(START_LAST)) begin
            st_nxt  = ST_RAW;
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      ST_RAW: begin
        if (bl_r == '0) begin
          unique case (hi_r)
            3'd0:    b = {7'd0, (32'(rl_r) <= 32'(BLOCK_MAX))};
            3'd1:    b = blk[7:0];
            3'd2:    b = blk[15:8];
            3'd3:    b = ~blk[7:0];
            default: b = ~blk[15:8];
          endcase
          if (adv) begin
            iupd = 1'b1;
            if (hi_r == 3'd4) begin
              hi_nxt = '0;
              bl_nxt = blk;
            end else begin
              hi_nxt = hi_r + 3'd1;
            end
          end
        end else begin
          b      = rawb;
          last_c = (rk_r == 3'd4) && !ti_r;
          if (adv) begin
            iupd   = 1'b1;
            al_nxt = alsum[15:0];
            ah_nxt = ahsum[15:0];
            bl_nxt = bl_r - 16'd1;
            rl_nxt = rl_r - RAW_W'(1);
            if (rk_r == 3'd4) begin
              idx_nxt = '0;
              st_nxt  = ti_r ? ST_TAIL : ST_IDLE;
            end else begin
              rk_nxt = rk_r + 3'd1;
            end
          end
        end
      end
      ST_TAIL: begin
        priority if (idx_r < 6'd4) begin
          b = be_byte(adl, idx_r[1:0]);
        end else if (idx_r < 6'd8) begin
          b = be_byte(~icrc_r, idx_r[1:0]);
        end else if (idx_r < 6'd12) begin
          b = 8'd0;
        end else if (idx_r < 6'd16) begin
          b = be_byte(32'h49454E44, idx_r[1:0]);
        end else begin
          b = be_byte(IEND_CRC, idx_r[1:0]);
        end
        last_c = (idx_r == 6'(TAIL_LAST));
        fe_c   = last_c;
        if (adv) begin
          iupd = (idx_r < 6'd4);
          if (idx_r == 6'(TAIL_LAST)) begin
            st_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    hcrc_nxt = hcrc_r;
    icrc_nxt = icrc_r;
    if (st_r == ST_IDLE && !q_empty && q_item.start) begin
      hcrc_nxt = CRC_INIT;
      icrc_nxt = CRC_INIT;
    end
    if (hupd) begin
      hcrc_nxt = crc_byte(hcrc_r, b);
    end
    if (iupd) begin
      icrc_nxt = crc_byte(icrc_r, b);
    end

    out_valid_nxt    = out_valid_r;
    out_byte_nxt     = out_byte_r;
    out_run_last_nxt = out_run_last_r;
    out_file_end_nxt = out_file_end_r;
    if (adv) begin
      ec_nxt           = (ec_r == 6'(MAX_RESULTS)) ? ec_r : ec_r + 6'd1;
      out_valid_nxt    = (ec_r < 6'(MAX_RESULTS));
      out_byte_nxt     = b;
      out_run_last_nxt = last_c || (ec_r == 6'(MAX_RESULTS - 1));
      out_file_end_nxt = fe_c;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      ec_r        <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      ec_r        <= ec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    rk_r           <= rk_nxt;
    hi_r           <= hi_nxt;
    rl_r           <= rl_nxt;
    bl_r           <= bl_nxt;
    al_r           <= al_nxt;
    ah_r           <= ah_nxt;
    hcrc_r         <= hcrc_nxt;
    icrc_r         <= icrc_nxt;
    px_r           <= px_nxt;
    ti_r           <= ti_nxt;
    out_byte_r     <= out_byte_nxt;
    out_run_last_r <= out_run_last_nxt;
    out_file_end_r <= out_file_end_nxt;
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_file_end_r |-> out_run_last_r) else $error("file end without run end");

  a_ec_range: assert property (@(posedge clk) disable iff (!rst_n)
    ec_r <= 6'(MAX_RESULTS)) else $error("word count past limit");

  a_raw_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RAW |-> rl_r != '0) else $error("raw data past image end");

endmodule

[test/png_stored_deflate_checker.sv]
module png_stored_deflate_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_pixel,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_run_last,
  input  logic        out_file_end,
  output int          fails,
  output int          pending,
  output int          bytes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {PH_WAIT, PH_PIXELS, PH_TAIL} phase_e;

  typedef struct {
    logic [7:0] b;
    logic       run_last;
    logic       file_end;
  } file_byte_t;

  file_byte_t  file_q[$];
  file_byte_t  step_buf[$];
  logic [10:0] side_reg;
  int          cur_side, row, col, blk_left, raw_left;
  logic [31:0] idat_crc, hdr_crc;
  int          a_lo, a_hi;
  phase_e      phase;

  function automatic logic [31:0] crc_upd(logic [31:0] c, logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) v = v[0] ? (32'hEDB88320 ^ (v >> 1)) : (v >> 1);
    return v;
  endfunction

  task automatic put(logic [7:0] b);
    file_byte_t e;
    if (step_buf.size() < pngsd_pkg::MAX_RESULTS) begin
      e.b = b; e.run_last = 0; e.file_end = 0;
      step_buf.push_back(e);
    end
  endtask

  task automatic put32(logic [31:0] v);
    put(v[31:24]); put(v[23:16]); put(v[15:8]); put(v[7:0]);
  endtask

  task automatic put_idat(logic [7:0] b);
    idat_crc = crc_upd(idat_crc, b);
    put(b);
  endtask

  task automatic put_hdr(logic [7:0] b);
    hdr_crc = crc_upd(hdr_crc, b);
    put(b);
  endtask

  task automatic put_raw(logic [7:0] b);
    int blk;
    logic [15:0] inv;
    if (blk_left == 0) begin
      blk = raw_left > 65535 ? 65535 : raw_left;
      inv = ~blk[15:0];
      put_idat(raw_left <= 65535 ? 8'd1 : 8'd0);
      put_idat(blk[7:0]); put_idat(blk[15:8]);
      put_idat(inv[7:0]); put_idat(inv[15:8]);
      blk_left = blk;
    end
    put_idat(b);
    a_lo = (a_lo + b) % 65521;
    a_hi = (a_hi + a_lo) % 65521;
    blk_left--;
    raw_left--;
  endtask

  task automatic open_image();
    logic [7:0] sig[8] = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
    logic [7:0] ihdr_tail[5] = '{8'd8, 8'd6, 8'd0, 8'd0, 8'd0};
    logic [31:0] s;
    int nblk;
    s = side_reg == 0 ? 1 : (side_reg > 1024 ? 1024 : side_reg);
    cur_side = s;
    row = 0; col = 0; blk_left = 0;
    raw_left = s * (1 + 4 * s);
    a_lo = 1; a_hi = 0;
    foreach (sig[i]) put(sig[i]);
    put32(32'd13);
    hdr_crc = '1;
    put_hdr("I"); put_hdr("H"); put_hdr("D"); put_hdr("R");
    for (int i = 0; i < 2; i++) begin
      put_hdr(s[31:24]); put_hdr(s[23:16]); put_hdr(s[15:8]); put_hdr(s[7:0]);
    end
    foreach (ihdr_tail[i]) put_hdr(ihdr_tail[i]);
    put32(~hdr_crc);
    nblk = (raw_left + 65534) / 65535;
    put32(6 + raw_left + 5 * nblk);
    idat_crc = '1;
    put_idat("I"); put_idat("D"); put_idat("A"); put_idat("T");
    put_idat(8'h78); put_idat(8'h01);
  endtask

  task automatic close_image();
    logic [31:0] adl;
    adl = {a_hi[15:0], a_lo[15:0]};
    put_idat(adl[31:24]); put_idat(adl[23:16]); put_idat(adl[15:8]); put_idat(adl[7:0]);
    put32(~idat_crc);
    put32(32'd0);
    hdr_crc = '1;
    put_hdr("I"); put_hdr("E"); put_hdr("N"); put_hdr("D");
    put32(~hdr_crc);
    step_buf[step_buf.size()-1].file_end = 1;
    phase = PH_WAIT;
  endtask

  task automatic encode_pixel(logic [31:0] px);
    step_buf.delete();
    if (phase == PH_TAIL) begin
      close_image();
    end else begin
      if (phase != PH_PIXELS) begin
        open_image();
        phase = PH_PIXELS;
      end
      if (col == 0) put_raw(8'd0);
      put_raw(px[31:24]); put_raw(px[23:16]); put_raw(px[15:8]); put_raw(px[7:0]);
      col++;
      if (col >= cur_side) begin
        col = 0;
        row++;
      end
      if (row >= cur_side) begin
        if (step_buf.size() + 20 <= pngsd_pkg::MAX_RESULTS) close_image();
        else phase = PH_TAIL;
      end
    end
    step_buf[step_buf.size()-1].run_last = 1;
    foreach (step_buf[i]) file_q.push_back(step_buf[i]);
  endtask

  always @(posedge clk) begin
    file_byte_t e;
    if (!rst_n) begin
      side_reg = 11'd1;
      phase = PH_WAIT;
      cur_side = 1;
      file_q.delete();
      fails = 0;
      bytes_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (file_q.size() == 0) begin
          $error("unexpected output word: byte %0h", out_byte);
          fails++;
        end else begin
          e = file_q.pop_front();
          if (out_byte !== e.b) begin
            $error("out_byte: expected %0h, got %0h", e.b, out_byte);
            fails++;
          end
          if (out_run_last !== e.run_last) begin
            $error("out_run_last: expected %0b, got %0b", e.run_last, out_run_last);
            fails++;
          end
          if (out_file_end !== e.file_end) begin
            $error("out_file_end: expected %0b, got %0b", e.file_end, out_file_end);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) encode_pixel(in_pixel);
      if (cfg_we) begin
        side_reg = cfg_wdata;
        phase = PH_WAIT;
      end
    end
    pending = file_q.size();
  end
endmodule

[test/tb_png_stored_deflate_encoder.sv]
module tb_png_stored_deflate_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1500000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] in_pixel = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_file_end;
  int          fails, pending, bytes_seen;
  int          cycles = 0;
  int          pixels_sent = 0;
  int          images = 0;
  bit          no_idle = 0;
  int          ready_hold = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  png_stored_deflate_encoder dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_run_last(out_run_last), .out_file_end(out_file_end)
  );

  png_stored_deflate_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_run_last(out_run_last), .out_file_end(out_file_end),
    .fails(fails), .pending(pending), .bytes_seen(bytes_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall, drawn per word
  always @(posedge clk) begin
    int h;
    if (!rst_n) begin
      out_ready <= 0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      out_ready <= 0;
      ready_hold <= ready_hold - 1;
    end else if (out_valid && out_ready) begin
      if (no_idle) begin
        out_ready <= 1;
      end else begin
        h = $urandom_range(0, 7);
        ready_hold <= h;
        out_ready <= (h == 0);
      end
    end else begin
      out_ready <= 1;
    end
  end

  task automatic send_pixel(logic [31:0] px);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_side(logic [10:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // full image; side 1 needs one extra word to carry the trailer
  task automatic send_image(int s, bit pause);
    int n, stop_at;
    n = s * s + (s == 1 ? 1 : 0);
    stop_at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      if (pause && i == stop_at) drain();
      send_pixel($urandom());
    end
    images++;
  endtask

  initial begin
    int s;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // side 0 reads as 1: trailer spills into the next word
    set_side(11'd0);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h00000000);
    set_side(11'd1);
    send_pixel(32'h00000000);
    send_pixel(32'h12345678);
    set_side(11'd2);
    send_pixel(32'h00000000);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'hAAAAAAAA);
    send_pixel(32'h55555555);
    // oversize side clamps; image abandoned by the next write
    set_side(11'd2047);
    repeat (3) send_pixel($urandom());
    set_side(11'd1024);
    repeat (2) send_pixel($urandom());
    set_side(11'd3);
    repeat (4) send_pixel($urandom());
    set_side(11'd3);
    images += 3;

    while (pixels_sent < 300) begin
      s = $urandom_range(1, 9);
      no_idle = ($urandom_range(0, 3) == 0);
      set_side(s[10:0]);
      send_image(s, $urandom_range(0, 2) == 0);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d images (sides 0..2047 written, abandoned images, stalls),", images);
    $display("%0d pixel words in, %0d file bytes checked.", pixels_sent, bytes_seen);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
